>>> hw/rtl/text_console_cursor_engine_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text console cursor engine
// Shared wrappers so every checked module reports the same way.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define TCCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define TCCE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hw/rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Types, constants and helpers shared by the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

    // Screen geometry
    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;

    // Field widths
    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_W = ATTR_W + CHAR_W;
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ROW_W  = $clog2(ROWS);

    // Reciprocal for position / COLS, exact over every ADDR_W-bit position
    localparam int DIV_SHIFT = ADDR_W + $clog2(COLS);
    localparam int DIV_RECIP = (2 ** DIV_SHIFT + COLS - 1) / COLS;
    localparam int RECIP_W   = ADDR_W + 2;
    localparam int PROD_W    = ADDR_W + RECIP_W;

    // Command queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Tab stops and cell values
    localparam int                TAB_STOP   = 4;
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_TEXT     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RAW      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SETPOS   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

    // Control characters
    localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;

    // Operations handed from front to back
    typedef enum logic [2:0] {
        OP_PRINT,
        OP_TAB,
        OP_NEWLINE,
        OP_RETURN,
        OP_SETPOS
    } op_t;

    // Write data of the text attribute register
    typedef logic [ATTR_W-1:0] cfg_data_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [ADDR_W-1:0] position;
    } in_item_t;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] cell_address;
        logic [CELL_W-1:0] cell_value;
        logic [ADDR_W-1:0] cursor_position;
        logic              scroll_up;
        logic              last;
    } out_item_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic [ADDR_W-1:0] position;
        logic [ROW_W-1:0]  row;
    } cmd_t;

    // Linear cell index of a row and column
    function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] idx;
        idx = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLS)) + ADDR_W'(col);
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tcce_front.sv
// ----------------------------------------------------------------------------
// tcce_front
// Accepts input transfers, decodes them into operations and splits a
// set-position request into its row ahead of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_front (
    input  wire                logic s_valid,
    output logic                     s_ready,
    input  wire tcce_pkg::in_item_t  s_data,
    input  wire                logic q_full,
    output logic                     push_valid,
    output tcce_pkg::cmd_t           push_cmd
);
    import tcce_pkg::*;

    logic [ADDR_W-1:0] pos_sat;
    logic [PROD_W-1:0] prod;
    op_t               op;

    // Take an item whenever the queue has room
    assign s_ready = !q_full;

    // Clamp the position to the last cell
    assign pos_sat = (32'(s_data.position) >= CELLS) ? ADDR_W'(CELLS - 1) : s_data.position;

    // Row by reciprocal multiply
    assign prod = PROD_W'(pos_sat) * PROD_W'(RECIP_W'(DIV_RECIP));

    // Decode function and control characters
    always_comb begin
        op = OP_PRINT;
        unique case (s_data.func)
            FUNC_TEXT: begin
                unique case (s_data.char_code)
                    CHAR_LF:  op = OP_NEWLINE;
                    CHAR_CR:  op = OP_RETURN;
                    CHAR_TAB: op = OP_TAB;
                    default:  op = OP_PRINT;
                endcase
            end
            FUNC_RAW:    op = OP_PRINT;
            FUNC_SETPOS: op = OP_SETPOS;
            default:     op = OP_PRINT;
        endcase
    end

    // Drop the reserved function code
    assign push_valid = s_valid && s_ready && (s_data.func != FUNC_RESERVED);

    always_comb begin
        push_cmd.op        = op;
        push_cmd.char_code = s_data.char_code;
        push_cmd.position  = pos_sat;
        push_cmd.row       = prod[DIV_SHIFT +: ROW_W];
    end

endmodule

`default_nettype wire

>>> hw/rtl/tcce_queue.sv
// ----------------------------------------------------------------------------
// tcce_queue
// Short command queue that decouples the decoder from the cell writer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_cursor_engine_defines.svh"

module tcce_queue (
    input  wire                 logic aclk,
    input  wire                 logic aresetn,
    input  wire                 logic push_valid,
    input  wire tcce_pkg::cmd_t       push_cmd,
    output logic                      q_full,
    input  wire                 logic pop,
    output logic                      head_valid,
    output tcce_pkg::cmd_t            head_cmd
);
    import tcce_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && head_valid) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push_valid && !(pop && head_valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!push_valid && pop && head_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `TCCE_ASSERT(a_queue_no_overflow, push_valid |-> !q_full || pop, "push into full queue")
    `TCCE_ASSERT(a_queue_count_range, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

>>> hw/rtl/tcce_back.sv
// ----------------------------------------------------------------------------
// tcce_back
// Executes queued operations against the cursor, one result per cycle when
// the output is free, holding each result in an output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_cursor_engine_defines.svh"

module tcce_back (
    input  wire                  logic aclk,
    input  wire                  logic aresetn,
    input  wire                  logic cfg_valid,
    input  wire tcce_pkg::cfg_data_t cfg_data,
    input  wire                  logic head_valid,
    input  wire tcce_pkg::cmd_t        head_cmd,
    output logic                       pop,
    output logic                       m_valid,
    input  wire                  logic m_ready,
    output tcce_pkg::out_item_t        m_data
);
    import tcce_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              m_valid_reg;
    out_item_t         m_data_reg, m_data_next;

    logic              out_free;
    logic              fire;
    logic [COL_W-1:0]  col_w;
    logic [ROW_W-1:0]  row_w;
    logic              scroll;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] val;
    logic              last_res;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = head_valid && out_free;
    assign pop      = fire && last_res;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Work out the result and the cursor after it
    always_comb begin
        col_w    = col_reg;
        row_w    = row_reg;
        scroll   = 1'b0;
        col_next = col_reg;
        row_next = row_reg;
        wr       = 1'b0;
        addr     = '0;
        val      = '0;
        last_res = 1'b1;

        // Wrap a full line before a cell write
        if ((head_cmd.op == OP_PRINT || head_cmd.op == OP_TAB) &&
            col_reg >= COL_W'(COLS)) begin
            col_w = '0;
            if (row_reg == ROW_W'(ROWS - 1)) begin
                scroll = 1'b1;
            end else begin
                row_w = row_reg + 1'b1;
            end
        end

        unique case (head_cmd.op)
            OP_PRINT: begin
                wr       = 1'b1;
                addr     = cell_index(row_w, col_w);
                val      = {attr_reg, head_cmd.char_code};
                col_next = col_w + 1'b1;
                row_next = row_w;
            end
            OP_TAB: begin
                wr       = 1'b1;
                addr     = cell_index(row_w, col_w);
                val      = BLANK_CELL;
                col_next = col_w + 1'b1;
                row_next = row_w;
                last_res = ((col_next % TAB_STOP) == 0) || (col_next == COL_W'(COLS));
            end
            OP_NEWLINE: begin
                col_next = '0;
                if (row_reg == ROW_W'(ROWS - 1)) begin
                    scroll = 1'b1;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            OP_RETURN: begin
                col_next = '0;
            end
            OP_SETPOS: begin
                row_next = head_cmd.row;
                col_next = COL_W'(head_cmd.position - cell_index(head_cmd.row, '0));
            end
            default: begin
                col_next = col_reg;
            end
        endcase

        m_data_next.write_valid     = wr;
        m_data_next.cell_address    = addr;
        m_data_next.cell_value      = val;
        m_data_next.cursor_position = cell_index(row_next, col_next);
        m_data_next.scroll_up       = scroll;
        m_data_next.last            = last_res;
    end

    // Cursor, attribute and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg    <= ATTR_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                attr_reg <= cfg_data;
            end
            if (fire) begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    `TCCE_ASSERT(a_cursor_range, (col_reg <= COL_W'(COLS)) && (row_reg <= ROW_W'(ROWS - 1)), "cursor out of range")
    `TCCE_ASSERT(a_scroll_last_row, m_valid_reg && m_data_reg.scroll_up && m_data_reg.write_valid |-> m_data_reg.cell_address >= ADDR_W'((ROWS - 1) * COLS), "scroll write off last row")
    `TCCE_ASSERT(a_nowrite_is_last, m_valid_reg && !m_data_reg.write_valid |-> m_data_reg.last && m_data_reg.cell_address == '0, "non-write result not final")
    `TCCE_ASSERT(a_tab_continues, fire && !pop |=> head_valid && head_cmd.op == OP_TAB, "multi-result op lost")

endmodule

`default_nettype wire

>>> hw/rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Character stream in, video cell writes and cursor updates out.
// ----------------------------------------------------------------------------
// Each input item other than function code 3 becomes one or more results,
// delivered from an output register at one result per cycle while taken.
// Printable and raw characters, line feed, carriage return and set-position
// each give one result; a tab gives one to four blank-cell writes, up to the
// next tab stop. The cell writer updates the cursor once per result. A
// two-entry command queue in front of it lets the input side take an item
// per cycle while there is room. Function code 3 is accepted and dropped.
// The text attribute register is to be written through the cfg channel by
// the user only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine (
    input  wire                  logic aclk,
    input  wire                  logic aresetn,
    input  wire                  logic s_valid,
    output logic                       s_ready,
    input  wire tcce_pkg::in_item_t    s_data,
    output logic                       m_valid,
    input  wire                  logic m_ready,
    output tcce_pkg::out_item_t        m_data,
    input  wire                  logic cfg_valid,
    output logic                       cfg_ready,
    input  wire tcce_pkg::cfg_data_t   cfg_data
);
    import tcce_pkg::*;

    logic q_full;
    logic push_valid;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Register writes complete at once
    assign cfg_ready = 1'b1;

    tcce_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    tcce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .q_full     (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tcce_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

>>> tb/text_console_cursor_engine_test.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_test
// Self-checking bench for the console cursor engine: a queue-fed driver pushes
// character, raw, set-position and reserved items, a model of the cursor
// predicts every cell write and cursor update, and a monitor compares each
// result transfer field by field. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine_test;
    import tcce_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        in_item_t item;
        int       gap;
        bit       hold;
    } pending_t;

    // Clock, reset and block ports
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_item_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_item_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ATTR_W-1:0] attr_wdata = '0;

    // Cursor model state
    logic [COL_W-1:0]  console_col = '0;
    logic [ROW_W-1:0]  console_row = '0;
    logic [ATTR_W-1:0] text_attr   = ATTR_RESET;

    pending_t  pending_items[$];
    out_item_t expected_cells[$];

    int  gap_count      = 0;
    int  stall_count    = 0;
    bit  rx_quiet       = 1'b0;
    int  cycle_count    = 0;
    int  mismatches     = 0;
    int  items_accepted = 0;
    int  results_seen   = 0;
    int  cell_writes    = 0;
    int  scrolls_seen   = 0;
    int  attr_settings  = 0;

    text_console_cursor_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (attr_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Cursor model
    // ------------------------------------------------------------------------

    // Queue one expected result; the cursor reported is the state after it
    function automatic void queue_result(bit wr, int addr, logic [CELL_W-1:0] val,
                                         bit scroll, bit lst);
        out_item_t r;
        r.write_valid     = wr;
        r.cell_address    = wr ? ADDR_W'(addr) : '0;
        r.cell_value      = wr ? val : '0;
        r.cursor_position = ADDR_W'(int'(console_row) * COLS + int'(console_col));
        r.scroll_up       = scroll;
        r.last            = lst;
        expected_cells.push_back(r);
    endfunction

    // Move down one row; pin to the bottom row and flag a scroll past it
    function automatic bit next_row();
        if (int'(console_row) + 1 > ROWS - 1) begin
            console_row = ROW_W'(ROWS - 1);
            return 1'b1;
        end
        console_row = console_row + 1'b1;
        return 1'b0;
    endfunction

    // Wrap to the next line when the current one is full
    function automatic bit wrap_full_line();
        if (int'(console_col) >= COLS) begin
            console_col = '0;
            return next_row();
        end
        return 1'b0;
    endfunction

    function automatic void print_cell(logic [CHAR_W-1:0] ch);
        bit scroll;
        int addr;
        scroll = wrap_full_line();
        addr = int'(console_row) * COLS + int'(console_col);
        console_col = console_col + 1'b1;
        queue_result(1'b1, addr, {text_attr, ch}, scroll, 1'b1);
    endfunction

    // Advance the model by one accepted item
    function automatic void step_console(in_item_t it);
        bit scroll;
        int p;
        int n;
        int room;
        int addr;
        case (it.func)
            FUNC_RAW: begin
                print_cell(it.char_code);
            end
            FUNC_SETPOS: begin
                p = int'(it.position);
                if (p >= CELLS)
                    p = CELLS - 1;
                console_col = COL_W'(p % COLS);
                console_row = ROW_W'(p / COLS);
                queue_result(1'b0, 0, '0, 1'b0, 1'b1);
            end
            FUNC_TEXT: begin
                if (it.char_code == CHAR_LF) begin
                    console_col = '0;
                    scroll = next_row();
                    queue_result(1'b0, 0, '0, scroll, 1'b1);
                end else if (it.char_code == CHAR_CR) begin
                    console_col = '0;
                    queue_result(1'b0, 0, '0, 1'b0, 1'b1);
                end else if (it.char_code == CHAR_TAB) begin
                    scroll = wrap_full_line();
                    n = TAB_STOP - (int'(console_col) % TAB_STOP);
                    room = COLS - int'(console_col);
                    if (n > room)
                        n = room;
                    for (int i = 0; i < n; i++) begin
                        addr = int'(console_row) * COLS + int'(console_col);
                        console_col = console_col + 1'b1;
                        queue_result(1'b1, addr, BLANK_CELL, scroll && i == 0, i + 1 == n);
                    end
                end else begin
                    print_cell(it.char_code);
                end
            end
            default: begin
                // reserved code: dropped, no results, no state change
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        pending_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                step_console(s_data);
                items_accepted++;
            end
            // Hold the item until its transfer, then idle or load the next one
            if (!s_valid || s_ready) begin
                if (pending_items.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (gap_count < pending_items[0].gap) begin
                    gap_count++;
                    s_valid <= 1'b0;
                end else if (pending_items[0].hold && expected_cells.size() != 0) begin
                    s_valid <= 1'b0;
                end else begin
                    next_item = pending_items.pop_front();
                    s_data <= next_item.item;
                    s_valid <= 1'b1;
                    gap_count = 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    task automatic log_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch: %s", what);
    endtask

    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_data.write_valid)
                    cell_writes++;
                if (m_data.scroll_up)
                    scrolls_seen++;
                if (expected_cells.size() == 0) begin
                    log_mismatch($sformatf("result %0d arrived with none expected",
                                           results_seen));
                end else begin
                    want = expected_cells.pop_front();
                    if (m_data.write_valid !== want.write_valid ||
                        m_data.cell_address !== want.cell_address ||
                        m_data.cell_value !== want.cell_value ||
                        m_data.cursor_position !== want.cursor_position ||
                        m_data.scroll_up !== want.scroll_up ||
                        m_data.last !== want.last)
                        log_mismatch($sformatf(
                            "result %0d exp wr=%0d addr=%0d val=%h cur=%0d scr=%0d last=%0d, got wr=%0d addr=%0d val=%h cur=%0d scr=%0d last=%0d",
                            results_seen, want.write_valid, want.cell_address,
                            want.cell_value, want.cursor_position, want.scroll_up,
                            want.last, m_data.write_valid, m_data.cell_address,
                            m_data.cell_value, m_data.cursor_position,
                            m_data.scroll_up, m_data.last));
                end
                stall_count = rx_quiet ? 0 : $urandom_range(0, 15);
            end else if (stall_count > 0) begin
                stall_count--;
            end
            m_ready <= (stall_count == 0);
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_item(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                            logic [ADDR_W-1:0] pos, bit quiet, bit hold = 1'b0);
        pending_t p;
        p.item.func      = func;
        p.item.char_code = ch;
        p.item.position  = pos;
        p.gap            = quiet ? 0 : $urandom_range(0, 15);
        p.hold           = hold;
        pending_items.push_back(p);
    endtask

    // Favor the bottom rows and line ends, where wraps and scrolls happen
    function automatic logic [ADDR_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return ADDR_W'($urandom_range(0, 2047));
        if (r < 7)
            return ADDR_W'($urandom_range(CELLS - 2 * COLS, CELLS - 1));
        return ADDR_W'($urandom_range(0, ROWS - 1) * COLS + $urandom_range(COLS - 5, COLS - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_text_char();
        if ($urandom_range(0, 3) != 0)
            return CHAR_W'($urandom_range(0, 255));
        case ($urandom_range(0, 2))
            0:       return CHAR_TAB;
            1:       return CHAR_LF;
            default: return CHAR_CR;
        endcase
    endfunction

    task automatic add_random(int count);
        int  r;
        bit  quiet;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            quiet = (i % 40) < 10;
            if (r < 50)
                add_item(FUNC_TEXT, pick_text_char(), ADDR_W'($urandom_range(0, 2047)),
                         quiet, i == count / 2);
            else if (r < 70)
                add_item(FUNC_RAW, CHAR_W'($urandom_range(0, 255)),
                         ADDR_W'($urandom_range(0, 2047)), quiet, i == count / 2);
            else if (r < 94)
                add_item(FUNC_SETPOS, CHAR_W'($urandom_range(0, 255)), pick_position(),
                         quiet, i == count / 2);
            else
                add_item(FUNC_RESERVED, CHAR_W'($urandom_range(0, 255)),
                         ADDR_W'($urandom_range(0, 2047)), quiet, 1'b0);
        end
    endtask

    // Wait for every item to transfer and every result to come back
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_cells.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_attr(logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        attr_wdata <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        text_attr = value;
        attr_settings++;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, control characters, wraps, scrolls, saturation
        add_item(FUNC_SETPOS, 8'h00, 11'd0, 1'b0);
        add_item(FUNC_RAW, 8'h00, 11'd0, 1'b0);
        add_item(FUNC_RAW, 8'hFF, 11'd2047, 1'b0);
        add_item(FUNC_TEXT, 8'h41, 11'd0, 1'b1);
        add_item(FUNC_TEXT, CHAR_TAB, 11'd0, 1'b1);
        add_item(FUNC_TEXT, CHAR_TAB, 11'd0, 1'b0);
        add_item(FUNC_TEXT, CHAR_CR, 11'd0, 1'b0);
        add_item(FUNC_TEXT, CHAR_LF, 11'd0, 1'b1);
        add_item(FUNC_RAW, CHAR_TAB, 11'd0, 1'b0);
        add_item(FUNC_TEXT, CHAR_TAB, 11'd0, 1'b0);
        add_item(FUNC_SETPOS, 8'hFF, 11'(COLS - 1), 1'b0);
        add_item(FUNC_TEXT, 8'h7E, 11'd0, 1'b1);
        add_item(FUNC_TEXT, 8'h42, 11'd0, 1'b1);
        add_item(FUNC_SETPOS, 8'h00, 11'(COLS - 2), 1'b0);
        add_item(FUNC_TEXT, CHAR_TAB, 11'd0, 1'b0);
        add_item(FUNC_TEXT, CHAR_TAB, 11'd0, 1'b1);
        add_item(FUNC_SETPOS, 8'h00, 11'(CELLS - 1), 1'b0, 1'b1);
        add_item(FUNC_RAW, 8'h43, 11'd0, 1'b1);
        add_item(FUNC_TEXT, CHAR_TAB, 11'd0, 1'b0);
        add_item(FUNC_SETPOS, 8'h00, 11'(CELLS - 1), 1'b0);
        add_item(FUNC_TEXT, 8'h44, 11'd0, 1'b1);
        add_item(FUNC_TEXT, 8'h45, 11'd0, 1'b1);
        add_item(FUNC_TEXT, CHAR_LF, 11'd0, 1'b0);
        add_item(FUNC_RESERVED, 8'hFF, 11'd2047, 1'b0);
        add_item(FUNC_SETPOS, 8'hFF, 11'd2047, 1'b0);
        add_item(FUNC_SETPOS, 8'h00, 11'(CELLS), 1'b1);
        wait_idle();

        // Random phases, each under its own attribute
        write_attr(8'h00);
        add_random(60);
        wait_idle();

        write_attr(8'hFF);
        rx_quiet = 1'b1;
        add_random(60);
        wait_idle();

        rx_quiet = 1'b0;
        write_attr(ATTR_W'($urandom_range(1, 254)));
        add_random(60);
        wait_idle();

        $display("covered %0d items and %0d results (%0d cell writes, %0d scrolls)",
                 items_accepted, results_seen, cell_writes, scrolls_seen);
        $display("under %0d attribute settings, %0d mismatches", attr_settings, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
